// ----- sv/b64u_dec_pkg.sv -----
// Types and the character map shared by the base64url decoder modules.
`timescale 1ns / 1ps
package b64u_dec_pkg;

	localparam int unsigned GRP_DEPTH = 2;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       has_byte;
		logic       msg_last;
	} out_item_t;

	// Results caused by one input item: up to three bytes or one bare end marker.
	typedef struct packed {
		logic [2:0][7:0] data;      // data[0] goes out first
		logic [1:0]      last_idx;  // index of the final result in the group
		logic            has_byte;
		logic            msg_end;
	} grp_t;

	// Bit 6 set means the character is not in the alphabet.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'h40;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = {1'b0, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			r = {1'b0, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2d) begin
			r = 7'd62;
		end else if (c == 8'h5f) begin
			r = 7'd63;
		end
		return r;
	endfunction

endpackage

// ----- sv/base64url_stream_decoder_core.sv -----
// Top level of the URL-safe base64 stream decoder.
//
//   channel | valid     | ready     | payload
//   input   | in_valid  | in_ready  | in_item  (char_in, end_of_text)
//   output  | out_valid | out_ready | out_item (byte_out, has_byte, msg_last)
//
// One character is taken per cycle while the two-entry group queue has room;
// a group that it completes is registered into the queue. The output side sends
// one byte per cycle while out_ready is high; a group keeps its queue entry until
// its last result has gone. in_ready depends only on queue fill, not on out_ready.
// Reset clears the accumulator, sextet count and the queue.
`timescale 1ns / 1ps
module base64url_stream_decoder_core
	import b64u_dec_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic fire, grp_push, q_full;
	grp_t grp;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;

	b64u_dec_unpack u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.in_item  (in_item),
		.grp_push (grp_push),
		.grp      (grp)
	);

	b64u_dec_grpq u_grpq (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_push  (grp_push),
		.grp       (grp),
		.full      (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- sv/b64u_dec_unpack.sv -----
// Decode stage: maps a character, accumulates sextets and forms a result group.
`timescale 1ns / 1ps
module b64u_dec_unpack
	import b64u_dec_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  in_item_t in_item,
	output logic     grp_push,
	output grp_t     grp
);

	logic [23:0] acc_q, acc_n, acc_shift;
	logic [1:0]  cnt_q, cnt_n;
	logic [6:0]  sx;
	logic        full_grp;

	always_comb begin
		sx        = sextet_of(in_item.char_in);
		acc_shift = {acc_q[17:0], sx[5:0]};
		acc_n     = acc_q;
		cnt_n     = cnt_q;
		full_grp  = 1'b0;
		grp       = '0;
		if (!sx[6]) begin
			if (cnt_q == 2'd3) begin
				full_grp      = 1'b1;
				grp.data[0]   = acc_shift[23:16];
				grp.data[1]   = acc_shift[15:8];
				grp.data[2]   = acc_shift[7:0];
				grp.last_idx  = 2'd2;
				grp.has_byte  = 1'b1;
				acc_n         = '0;
				cnt_n         = '0;
			end else begin
				acc_n = acc_shift;
				cnt_n = cnt_q + 2'd1;
			end
		end
		if (in_item.end_of_text) begin
			grp.msg_end = 1'b1;
			case (cnt_n)
				2'd2: begin
					grp.data[0]  = acc_n[11:4];
					grp.last_idx = 2'd0;
					grp.has_byte = 1'b1;
				end
				2'd3: begin
					grp.data[0]  = acc_n[17:10];
					grp.data[1]  = acc_n[9:2];
					grp.last_idx = 2'd1;
					grp.has_byte = 1'b1;
				end
				default: begin
					// a lone sextet is dropped; bare marker unless a full group went out
					if (!full_grp) begin
						grp.last_idx = 2'd0;
						grp.has_byte = 1'b0;
					end
				end
			endcase
			acc_n = '0;
			cnt_n = '0;
		end
		grp_push = fire && (full_grp || in_item.end_of_text);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (fire) begin
			acc_q <= acc_n;
			cnt_q <= cnt_n;
		end
	end

endmodule

// ----- sv/b64u_dec_grpq.sv -----
// Two-entry group queue with a serializer that sends one result item per cycle while out_ready is high.
`timescale 1ns / 1ps
module b64u_dec_grpq
	import b64u_dec_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      grp_push,
	input  grp_t      grp,
	output logic      full,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	grp_t       mem_q [GRP_DEPTH];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	grp_t       head;
	logic       res_pop, grp_pop;

	always_comb begin
		head               = mem_q[rd_q];
		out_valid          = (cnt_q != 2'd0);
		full               = (cnt_q == 2'(GRP_DEPTH));
		out_item.byte_out  = head.data[idx_q];
		out_item.has_byte  = head.has_byte;
		out_item.msg_last  = head.msg_end && (idx_q == head.last_idx);
		res_pop            = out_valid && out_ready;
		grp_pop            = res_pop && (idx_q == head.last_idx);
	end

	always_ff @(posedge clk) begin
		if (grp_push) begin
			mem_q[wr_q] <= grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (grp_push) begin
				wr_q <= ~wr_q;
			end
			if (grp_pop) begin
				rd_q  <= ~rd_q;
				idx_q <= '0;
			end else if (res_pop) begin
				idx_q <= idx_q + 2'd1;
			end
			case ({grp_push, grp_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
